// ===== design/nfc_epaper_image_sequencer_macros.svh =====
// Assertion macros shared by the image sequencer modules.
`ifndef NFC_EPAPER_IMAGE_SEQUENCER_MACROS_SVH
`define NFC_EPAPER_IMAGE_SEQUENCER_MACROS_SVH

// Same-cycle implication, checked on clk, disabled while arst_n is low.
`define NFCSEQ_CHK_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on clk, disabled while arst_n is low.
`define NFCSEQ_CHK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/nfcseq_pkg.sv =====
// Shared types, constants and helper functions of the image sequencer.
`timescale 1ns / 1ps
`default_nettype none
package nfcseq_pkg;

	localparam int BYTES_PER_PACKET_DEF = 100;

	localparam int CFG_ADDR_W = 4;
	localparam int CFG_DATA_W = 32;

	localparam logic [1:0] REG_THRESHOLD  = 2'd0;
	localparam logic [1:0] REG_PACKETS    = 2'd1;
	localparam logic [1:0] REG_POLL_LIMIT = 2'd2;

	localparam logic [7:0] THRESHOLD_RST  = 8'd128;
	localparam logic [9:0] PACKETS_RST    = 10'd150;
	localparam logic [9:0] POLL_LIMIT_RST = 10'd200;

	localparam logic [1:0] KIND_START = 2'd0;
	localparam logic [1:0] KIND_REPLY = 2'd1;
	localparam logic [1:0] KIND_PIXEL = 2'd2;
	localparam logic [1:0] KIND_SPARE = 2'd3;

	localparam logic OUT_FRAME  = 1'b0;
	localparam logic OUT_STATUS = 1'b1;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_LINK     = 3'd1;
	localparam logic [2:0] ST_CMD_REJ  = 3'd2;
	localparam logic [2:0] ST_PKT_REJ  = 3'd3;
	localparam logic [2:0] ST_TIMEOUT  = 3'd4;

	localparam logic [7:0] BYTE_PREFIX   = 8'hCD;
	localparam logic [7:0] BYTE_ZERO     = 8'h00;
	localparam logic [7:0] BYTE_INIT_ARG = 8'h0A;
	localparam logic [7:0] BYTE_LOAD_ARG = 8'h00;
	localparam logic [7:0] BYTE_LOAD     = 8'h07;
	localparam logic [7:0] BYTE_DATA     = 8'h08;
	localparam logic [7:0] BYTE_REFRESH  = 8'h09;
	localparam logic [7:0] BYTE_POLL     = 8'h0A;
	localparam logic [7:0] BYTE_SHUTDOWN = 8'h04;
	localparam logic [7:0] BYTE_READY    = 8'hFF;

	localparam int MAX_RESULTS = 3;
	localparam int QDEPTH      = 4;
	localparam int QPTR_W      = $clog2(QDEPTH);
	localparam int QCNT_W      = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic       out_kind;
		logic [7:0] frame_byte;
		logic       frame_last;
		logic [2:0] status;
	} result_t;

	typedef struct packed {
		logic [1:0]                    n;
		result_t [MAX_RESULTS-1:0]     res;
	} push_t;

	typedef struct packed {
		logic [7:0] threshold;
		logic [9:0] packets;
		logic [9:0] poll_limit;
	} cfg_t;

	function automatic result_t frame_res(input logic [7:0] b, input logic last);
		result_t r;
		r.out_kind   = OUT_FRAME;
		r.frame_byte = b;
		r.frame_last = last;
		r.status     = ST_OK;
		return r;
	endfunction

	function automatic result_t status_res(input logic [2:0] st);
		result_t r;
		r.out_kind   = OUT_STATUS;
		r.frame_byte = BYTE_ZERO;
		r.frame_last = 1'b0;
		r.status     = st;
		return r;
	endfunction

	// Second byte of fixed command k.
	function automatic logic [7:0] cmd_code(input logic [2:0] k);
		logic [7:0] c;
		case (k)
			3'd0: c = 8'h0D;
			3'd1: c = 8'h00;
			3'd2: c = 8'h01;
			3'd3: c = 8'h02;
			3'd4: c = 8'h03;
			3'd5: c = 8'h05;
			3'd6: c = 8'h06;
			3'd7: c = 8'h07;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

// ===== design/nfcseq_cfg.sv =====
// APB register file holding threshold, packet count and poll limit.
`timescale 1ns / 1ps
`default_nettype none
module nfcseq_cfg (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                psel,
	input  wire logic                                penable,
	input  wire logic                                pwrite,
	input  wire logic [nfcseq_pkg::CFG_ADDR_W-1:0]   paddr,
	input  wire logic [nfcseq_pkg::CFG_DATA_W-1:0]   pwdata,
	output logic      [nfcseq_pkg::CFG_DATA_W-1:0]   prdata,
	output logic                                     pready,
	output nfcseq_pkg::cfg_t                         cfg
);
	import nfcseq_pkg::*;

	logic [7:0] threshold_q;
	logic [9:0] packets_q;
	logic [9:0] poll_limit_q;
	logic       wr_en;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q  <= THRESHOLD_RST;
			packets_q    <= PACKETS_RST;
			poll_limit_q <= POLL_LIMIT_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_THRESHOLD:  threshold_q  <= pwdata[7:0];
				REG_PACKETS:    packets_q    <= pwdata[9:0];
				REG_POLL_LIMIT: poll_limit_q <= pwdata[9:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_THRESHOLD:  prdata = {{(CFG_DATA_W-8){1'b0}}, threshold_q};
			REG_PACKETS:    prdata = {{(CFG_DATA_W-10){1'b0}}, packets_q};
			REG_POLL_LIMIT: prdata = {{(CFG_DATA_W-10){1'b0}}, poll_limit_q};
			default:        prdata = '0;
		endcase
	end

	assign cfg.threshold  = threshold_q;
	assign cfg.packets    = packets_q;
	assign cfg.poll_limit = poll_limit_q;

endmodule
`default_nettype wire

// ===== design/nfcseq_core.sv =====
// Input register and sequencing step: tag command flow, pixel packing, polling.
`timescale 1ns / 1ps
`default_nettype none
module nfcseq_core #(
	parameter int BYTES_PER_PACKET = nfcseq_pkg::BYTES_PER_PACKET_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [1:0]        kind,
	input  wire logic [7:0]        pixel_value,
	input  wire logic              link_error,
	input  wire logic [7:0]        reply_first,
	input  wire logic [7:0]        reply_second,
	input  wire nfcseq_pkg::cfg_t  cfg,
	input  wire logic              room,
	output nfcseq_pkg::push_t      push
);
	import nfcseq_pkg::*;
	`include "nfc_epaper_image_sequencer_macros.svh"

	localparam int PC_W = $clog2(BYTES_PER_PACKET + 1);
	localparam logic [PC_W-1:0] PC_END = PC_W'(BYTES_PER_PACKET);
	localparam logic [7:0] HDR_LEN = 8'(BYTES_PER_PACKET);

	localparam logic [3:0] PH_IDLE    = 4'd0;
	localparam logic [3:0] PH_CMD0    = 4'd1;
	localparam logic [3:0] PH_CMD7    = 4'd8;
	localparam logic [3:0] PH_FILL    = 4'd9;
	localparam logic [3:0] PH_PKT     = 4'd10;
	localparam logic [3:0] PH_REFRESH = 4'd11;
	localparam logic [3:0] PH_POLL    = 4'd12;
	localparam logic [3:0] PH_SHUT    = 4'd13;

	logic       valid_s1;
	logic [1:0] kind_s1;
	logic [7:0] pixel_s1;
	logic       lerr_s1;
	logic [7:0] r0_s1;
	logic [7:0] r1_s1;
	logic       go;

	logic [3:0]      phase_q, phase_d;
	logic [9:0]      sent_q, sent_d;
	logic [PC_W-1:0] pc_q, pc_d, pc_inc;
	logic [2:0]      bc_q, bc_d;
	logic [7:0]      shift_q, shift_d;
	logic [9:0]      poll_q, poll_d;
	logic [2:0]      cmd_k;

	assign go       = valid_s1 & room;
	assign in_ready = ~valid_s1 | room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			kind_s1  <= kind;
			pixel_s1 <= pixel_value;
			lerr_s1  <= link_error;
			r0_s1    <= reply_first;
			r1_s1    <= reply_second;
		end
	end

	assign pc_inc = pc_q + PC_W'(1);
	assign cmd_k  = phase_q[2:0];

	always_comb begin
		phase_d = phase_q;
		sent_d  = sent_q;
		pc_d    = pc_q;
		bc_d    = bc_q;
		shift_d = shift_q;
		poll_d  = poll_q;
		push.n  = 2'd0;
		push.res[0] = '0;
		push.res[1] = '0;
		push.res[2] = '0;
		case (kind_s1)
			KIND_START: begin
				sent_d  = '0;
				pc_d    = '0;
				bc_d    = '0;
				shift_d = '0;
				poll_d  = '0;
				phase_d = PH_CMD0;
				push.res[0] = frame_res(BYTE_PREFIX, 1'b0);
				push.res[1] = frame_res(cmd_code(3'd0), 1'b1);
				push.n = 2'd2;
			end
			KIND_PIXEL: begin
				if (phase_q == PH_FILL) begin
					shift_d = {shift_q[6:0], (pixel_s1 > cfg.threshold)};
					bc_d    = bc_q + 3'd1;
					if (bc_q == 3'd7) begin
						push.n = 2'd1;
						if (pc_inc == PC_END) begin
							pc_d    = '0;
							phase_d = PH_PKT;
							if (sent_q != '1)
								sent_d = sent_q + 10'd1;
							push.res[0] = frame_res(shift_d, 1'b1);
						end else begin
							pc_d = pc_inc;
							push.res[0] = frame_res(shift_d, 1'b0);
						end
					end
				end
			end
			KIND_REPLY: begin
				if (phase_q != PH_IDLE && phase_q != PH_FILL && phase_q <= PH_SHUT) begin
					if (lerr_s1) begin
						phase_d = PH_IDLE;
						push.res[0] = status_res(ST_LINK);
						push.n = 2'd1;
					end else if (phase_q == PH_POLL) begin
						if (r0_s1 == BYTE_READY && r1_s1 == BYTE_ZERO) begin
							phase_d = PH_SHUT;
							push.res[0] = frame_res(BYTE_PREFIX, 1'b0);
							push.res[1] = frame_res(BYTE_SHUTDOWN, 1'b1);
							push.n = 2'd2;
						end else if (poll_q > cfg.poll_limit) begin
							phase_d = PH_IDLE;
							push.res[0] = status_res(ST_TIMEOUT);
							push.n = 2'd1;
						end else begin
							if (poll_q != '1)
								poll_d = poll_q + 10'd1;
							push.res[0] = frame_res(BYTE_PREFIX, 1'b0);
							push.res[1] = frame_res(BYTE_POLL, 1'b1);
							push.n = 2'd2;
						end
					end else if (r0_s1 != BYTE_ZERO || r1_s1 != BYTE_ZERO) begin
						phase_d = PH_IDLE;
						push.res[0] = status_res((phase_q == PH_PKT) ? ST_PKT_REJ : ST_CMD_REJ);
						push.n = 2'd1;
					end else if (phase_q < PH_CMD7) begin
						// next fixed command: index equals the current phase code
						phase_d = phase_q + 4'd1;
						push.res[0] = frame_res(BYTE_PREFIX, 1'b0);
						if (cmd_k == 3'd1) begin
							push.res[1] = frame_res(cmd_code(cmd_k), 1'b0);
							push.res[2] = frame_res(BYTE_INIT_ARG, 1'b1);
							push.n = 2'd3;
						end else if (cmd_k == 3'd7) begin
							push.res[1] = frame_res(BYTE_LOAD, 1'b0);
							push.res[2] = frame_res(BYTE_LOAD_ARG, 1'b1);
							push.n = 2'd3;
						end else begin
							push.res[1] = frame_res(cmd_code(cmd_k), 1'b1);
							push.n = 2'd2;
						end
					end else if (phase_q == PH_CMD7 || phase_q == PH_PKT) begin
						push.res[0] = frame_res(BYTE_PREFIX, 1'b0);
						if (sent_q >= cfg.packets) begin
							phase_d = PH_REFRESH;
							push.res[1] = frame_res(BYTE_REFRESH, 1'b1);
							push.n = 2'd2;
						end else begin
							phase_d = PH_FILL;
							pc_d    = '0;
							bc_d    = '0;
							shift_d = '0;
							push.res[1] = frame_res(BYTE_DATA, 1'b0);
							push.res[2] = frame_res(HDR_LEN, 1'b0);
							push.n = 2'd3;
						end
					end else if (phase_q == PH_REFRESH) begin
						phase_d = PH_POLL;
						poll_d  = 10'd1;
						push.res[0] = frame_res(BYTE_PREFIX, 1'b0);
						push.res[1] = frame_res(BYTE_POLL, 1'b1);
						push.n = 2'd2;
					end else begin
						phase_d = PH_IDLE;
						push.res[0] = status_res(ST_OK);
						push.n = 2'd1;
					end
				end
			end
			default: ;
		endcase
		if (!go)
			push.n = 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			sent_q  <= '0;
			pc_q    <= '0;
			bc_q    <= '0;
			shift_q <= '0;
			poll_q  <= '0;
		end else if (go) begin
			phase_q <= phase_d;
			sent_q  <= sent_d;
			pc_q    <= pc_d;
			bc_q    <= bc_d;
			shift_q <= shift_d;
			poll_q  <= poll_d;
		end
	end

	`NFCSEQ_CHK_NOW(a_spare_silent, go && kind_s1 == KIND_SPARE, push.n == 2'd0,
		"spare kind produced results")
	`NFCSEQ_CHK_NEXT(a_start_cmd0, go && kind_s1 == KIND_START, phase_q == PH_CMD0,
		"start did not enter first command phase")
	`NFCSEQ_CHK_NEXT(a_status_idle, go && push.n != 2'd0 && push.res[0].out_kind == OUT_STATUS,
		phase_q == PH_IDLE, "status result left the sequencer busy")

endmodule
`default_nettype wire

// ===== design/nfcseq_outq.sv =====
// Result queue: takes up to three results per cycle, delivers one per transaction.
`timescale 1ns / 1ps
`default_nettype none
module nfcseq_outq (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire nfcseq_pkg::push_t push,
	output logic                   room,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic                   out_kind,
	output logic [7:0]             frame_byte,
	output logic                   frame_last,
	output logic [2:0]             status
);
	import nfcseq_pkg::*;
	`include "nfc_epaper_image_sequencer_macros.svh"

	result_t mem [QDEPTH];
	logic [QPTR_W-1:0] head_q, tail_q;
	logic [QCNT_W-1:0] count_q, count_left;
	logic              pop;
	result_t           head_res;

	assign pop        = out_valid & out_ready;
	assign out_valid  = (count_q != '0);
	assign count_left = count_q - QCNT_W'(pop);
	// room for a worst-case item once this cycle's pop is counted
	assign room       = (count_left <= QCNT_W'(QDEPTH - MAX_RESULTS));

	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_RESULTS; i++) begin
			if (i < int'(push.n))
				mem[tail_q + QPTR_W'(i)] <= push.res[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (pop)
				head_q <= head_q + QPTR_W'(1);
			tail_q  <= tail_q + QPTR_W'(push.n);
			count_q <= count_left + QCNT_W'(push.n);
		end
	end

	assign head_res   = mem[head_q];
	assign out_kind   = head_res.out_kind;
	assign frame_byte = head_res.frame_byte;
	assign frame_last = head_res.frame_last;
	assign status     = head_res.status;

	`NFCSEQ_CHK_NOW(a_cnt_bound, 1'b1, count_q <= QCNT_W'(QDEPTH), "queue count over depth")
	`NFCSEQ_CHK_NOW(a_no_overflow, push.n != 2'd0,
		(count_left + QCNT_W'(push.n)) <= QCNT_W'(QDEPTH), "push overflows the queue")
	`NFCSEQ_CHK_NEXT(a_empty_stays, count_q == '0 && push.n == 2'd0, !out_valid,
		"queue shows a result without a push")

endmodule
`default_nettype wire

// ===== design/nfc_epaper_image_sequencer.sv =====
// Top level of the NFC e-paper image sequencer.
//
//   channel   direction  handshake            payload
//   in        to block   in_valid/in_ready    kind, pixel_value, link_error, reply_*
//   out       from block out_valid/out_ready  out_kind, frame_byte, frame_last, status
//   config    to block   APB psel/penable     paddr, pwdata, prdata
//
// An accepted item is held in the input register; its step runs once the queue has room
// and puts zero to three results into a four-entry result queue.
// The input side takes one item per cycle while the queue can absorb three results;
// sustained rate is set by the output port: one result per cycle.
// A stalled output stops the input once the queue holds more than one result.
// Reset clears the sequencer to idle, the queue to empty and registers to defaults.
`timescale 1ns / 1ps
`default_nettype none
module nfc_epaper_image_sequencer #(
	parameter int BYTES_PER_PACKET = nfcseq_pkg::BYTES_PER_PACKET_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic [1:0]                        kind,
	input  wire logic [7:0]                        pixel_value,
	input  wire logic                              link_error,
	input  wire logic [7:0]                        reply_first,
	input  wire logic [7:0]                        reply_second,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic                                   out_kind,
	output logic [7:0]                             frame_byte,
	output logic                                   frame_last,
	output logic [2:0]                             status,
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [nfcseq_pkg::CFG_ADDR_W-1:0] paddr,
	input  wire logic [nfcseq_pkg::CFG_DATA_W-1:0] pwdata,
	output logic      [nfcseq_pkg::CFG_DATA_W-1:0] prdata,
	output logic                                   pready
);
	import nfcseq_pkg::*;

	cfg_t  cfg;
	push_t push;
	logic  room;

	nfcseq_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	nfcseq_core #(
		.BYTES_PER_PACKET (BYTES_PER_PACKET)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.kind         (kind),
		.pixel_value  (pixel_value),
		.link_error   (link_error),
		.reply_first  (reply_first),
		.reply_second (reply_second),
		.cfg          (cfg),
		.room         (room),
		.push         (push)
	);

	nfcseq_outq u_outq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.room       (room),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_kind   (out_kind),
		.frame_byte (frame_byte),
		.frame_last (frame_last),
		.status     (status)
	);

endmodule
`default_nettype wire
